// ===== rtl/tewb_pkg.sv =====
// ----------------------------------------------------------------------------
// tewb_pkg
// Shared constants, codes and controller/datapath interface types for the
// timestamped event word buffer.
// ----------------------------------------------------------------------------
package tewb_pkg;

  localparam int BUFFER_WORDS = 1024;
  localparam int IDX_W        = $clog2(BUFFER_WORDS + 1);
  localparam int ADDR_W       = $clog2(BUFFER_WORDS);
  localparam int WORD_W       = 32;
  localparam int TIME_W       = 24;
  localparam int MSG_W        = 24;
  localparam int DELTA_W      = WORD_W - TIME_W;

  localparam logic [DELTA_W-1:0] ESC_BYTE    = 8'hFF;
  localparam logic [DELTA_W-1:0] DELTA_LIMIT = 8'hFF;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_SHORT = 2'd1,
    SRC_MSG   = 2'd2
  } src_t;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_WR_HEAD = 3'd1,
    S_WR_MSG  = 3'd2,
    S_RD_HEAD = 3'd3,
    S_RD_WORD = 3'd4,
    S_RD_MSG  = 3'd5
  } state_t;

  typedef struct packed {
    logic    load;
    logic    wr_head;
    logic    wr_msg;
    logic    rd_head;
    logic    rd_word;
    logic    rd_msg;
    logic    post;
    status_t code;
    src_t    src;
  } tewb_cmd_t;

  typedef struct packed {
    logic wr_escape;
    logic wr_refuse;
    logic rd_empty;
    logic rd_escape;
    logic rd_last;
  } tewb_stat_t;

endpackage

// ===== rtl/tewb_dp.sv =====
// ----------------------------------------------------------------------------
// tewb_dp
// Datapath: word store, write/read pointers and times, event encode and
// decode, and the result register.
// ----------------------------------------------------------------------------
module tewb_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tewb_pkg::TIME_W-1:0]   event_time_in,
  input  logic [tewb_pkg::MSG_W-1:0]    message_in,
  input  tewb_pkg::tewb_cmd_t           cmd,
  output tewb_pkg::tewb_stat_t          stat,
  output logic [1:0]                    status,
  output logic [tewb_pkg::TIME_W-1:0]   event_time_out,
  output logic [tewb_pkg::MSG_W-1:0]    message_out
);
  import tewb_pkg::*;

  logic [WORD_W-1:0] word_store [BUFFER_WORDS];
  logic [WORD_W-1:0] mem_q;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata;

  logic [TIME_W-1:0] time_r;
  logic [MSG_W-1:0]  msg_r;
  logic [IDX_W-1:0]  write_index;
  logic [IDX_W-1:0]  write_index_next;
  logic [IDX_W-1:0]  read_index;
  logic [IDX_W-1:0]  read_index_next;
  logic [TIME_W-1:0] write_time;
  logic [TIME_W-1:0] read_time;
  logic [TIME_W-1:0] read_time_next;
  logic [IDX_W-1:0]  wr_idx_inc;
  logic [IDX_W-1:0]  rd_idx_inc;
  logic [TIME_W-1:0] dt;
  logic [TIME_W-1:0] sum_time;
  status_t           res_status;
  logic [TIME_W-1:0] res_time;
  logic [MSG_W-1:0]  res_msg;

  assign dt         = time_r - write_time;
  assign wr_idx_inc = write_index + IDX_W'(1);
  assign rd_idx_inc = read_index + IDX_W'(1);
  assign sum_time   = read_time + TIME_W'(mem_q[WORD_W-1:TIME_W]);

  assign stat.wr_escape = (dt >= TIME_W'(DELTA_LIMIT));
  assign stat.wr_refuse = stat.wr_escape ? (write_index > IDX_W'(BUFFER_WORDS - 2))
                                         : (write_index >= IDX_W'(BUFFER_WORDS));
  assign stat.rd_empty  = (read_index >= write_index);
  assign stat.rd_escape = (mem_q[WORD_W-1:TIME_W] == ESC_BYTE);
  assign stat.rd_last   = (rd_idx_inc >= write_index);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = write_index[ADDR_W-1:0];
    mem_wdata = {DELTA_W'(0), msg_r};
    if (cmd.wr_head) begin
      mem_we = 1'b1;
      if (stat.wr_escape) begin
        mem_wdata = {ESC_BYTE, time_r};
      end else begin
        mem_wdata = {dt[DELTA_W-1:0], msg_r};
      end
    end else if (cmd.wr_msg) begin
      mem_we   = 1'b1;
      mem_addr = wr_idx_inc[ADDR_W-1:0];
    end else if (cmd.rd_head) begin
      mem_re   = 1'b1;
      mem_addr = read_index[ADDR_W-1:0];
    end else if (cmd.rd_word && stat.rd_escape) begin
      mem_re   = 1'b1;
      mem_addr = rd_idx_inc[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_store[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= word_store[mem_addr];
    end
  end

  always_comb begin
    write_index_next = write_index;
    read_index_next  = read_index;
    read_time_next   = read_time;
    if (cmd.wr_head && !stat.wr_escape) begin
      write_index_next = wr_idx_inc;
    end
    if (cmd.wr_msg) begin
      write_index_next = write_index + IDX_W'(2);
    end
    if (cmd.rd_word) begin
      if (stat.rd_escape) begin
        read_time_next = mem_q[TIME_W-1:0];
      end else begin
        read_time_next  = sum_time;
        read_index_next = rd_idx_inc;
      end
    end
    if (cmd.rd_msg) begin
      read_index_next = read_index + IDX_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      time_r <= event_time_in;
      msg_r  <= message_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      write_time  <= '0;
      read_time   <= '0;
    end else begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      read_time   <= read_time_next;
      if ((cmd.wr_head && !stat.wr_escape) || cmd.wr_msg) begin
        write_time <= time_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_status <= ST_OK;
      res_time   <= '0;
      res_msg    <= '0;
    end else if (cmd.post) begin
      res_status <= cmd.code;
      case (cmd.src)
        SRC_SHORT: begin
          res_time <= sum_time;
          res_msg  <= mem_q[MSG_W-1:0];
        end
        SRC_MSG: begin
          res_time <= read_time;
          res_msg  <= mem_q[MSG_W-1:0];
        end
        default: begin
          res_time <= '0;
          res_msg  <= '0;
        end
      endcase
    end
  end

  assign status         = res_status;
  assign event_time_out = res_time;
  assign message_out    = res_msg;

`ifndef ASSERT_OFF
  a_wr_bound: assert property (@(posedge clk) disable iff (rst)
    write_index <= IDX_W'(BUFFER_WORDS))
    else $error("write pointer beyond store");
  a_rd_behind: assert property (@(posedge clk) disable iff (rst)
    read_index <= write_index)
    else $error("read pointer passed write pointer");
  a_ptr_mono: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_msg |=> write_index == $past(write_index) + IDX_W'(2))
    else $error("escape write did not advance by two words");
`endif

endmodule

// ===== rtl/tewb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tewb_ctrl
// Controller: sequences word writes and reads over the single store port and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module tewb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tewb_pkg::tewb_stat_t stat,
  output tewb_pkg::tewb_cmd_t  cmd
);
  import tewb_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.post) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (op == CMD_READ) ? S_RD_HEAD : S_WR_HEAD;
        end
      end
      S_WR_HEAD: begin
        if (slot_free) begin
          if (stat.wr_refuse) begin
            cmd.post   = 1'b1;
            cmd.code   = ST_FULL;
            state_next = S_IDLE;
          end else if (stat.wr_escape) begin
            cmd.wr_head = 1'b1;
            state_next  = S_WR_MSG;
          end else begin
            cmd.wr_head = 1'b1;
            cmd.post    = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      S_WR_MSG: begin
        if (slot_free) begin
          cmd.wr_msg = 1'b1;
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_HEAD: begin
        if (stat.rd_empty) begin
          if (slot_free) begin
            cmd.post   = 1'b1;
            cmd.code   = ST_EMPTY;
            state_next = S_IDLE;
          end
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = S_RD_WORD;
        end
      end
      S_RD_WORD: begin
        if (slot_free) begin
          if (stat.rd_escape && stat.rd_last) begin
            cmd.post   = 1'b1;
            cmd.code   = ST_EMPTY;
            state_next = S_IDLE;
          end else if (stat.rd_escape) begin
            cmd.rd_word = 1'b1;
            state_next  = S_RD_MSG;
          end else begin
            cmd.rd_word = 1'b1;
            cmd.post    = 1'b1;
            cmd.src     = SRC_SHORT;
            state_next  = S_IDLE;
          end
        end
      end
      S_RD_MSG: begin
        if (slot_free) begin
          cmd.rd_msg = 1'b1;
          cmd.post   = 1'b1;
          cmd.src    = SRC_MSG;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_post_free: assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> (!out_valid || out_ready))
    else $error("result posted over a pending word");
  a_end_posts: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) && (state_next == S_IDLE) |-> cmd.post)
    else $error("item finished without a result");
  a_no_refused_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_head || cmd.wr_msg) |-> !stat.wr_refuse)
    else $error("write issued without room");
`endif

endmodule

// ===== rtl/timestamped_event_word_buffer.sv =====
// ----------------------------------------------------------------------------
// timestamped_event_word_buffer
// Linear store of time-stamped 24-bit messages packed as 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: cmd = 0
//   appends an event (event_time_in, message_in), cmd = 1 fetches the next
//   event. Output channel (out_valid/out_ready) returns one result word per
//   command: status, event_time_out, message_out.
//   A write under 255 ticks after the last write takes one store word;
//   otherwise it takes an escape word plus a message word.
//   A refused or short write and an empty read post from the head state;
//   other commands post once their last word is written or fetched. The
//   store has one port, so words move one at a time; a new command is taken
//   the cycle after the previous result is posted. in_ready is high only
//   while the controller is idle, and it stays high while a posted result
//   waits; when out_ready is low the next command stalls until the result
//   register drains: a write before its first store word, a read once its
//   head word is fetched, an empty read before posting.
//   Reset clears both pointers and both running times; store contents are
//   not cleared, and the read side never reaches unwritten words.
// ----------------------------------------------------------------------------
module timestamped_event_word_buffer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [tewb_pkg::TIME_W-1:0] event_time_in,
  input  logic [tewb_pkg::MSG_W-1:0]  message_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [tewb_pkg::TIME_W-1:0] event_time_out,
  output logic [tewb_pkg::MSG_W-1:0]  message_out
);
  import tewb_pkg::*;

  tewb_cmd_t  dp_cmd;
  tewb_stat_t dp_stat;

  tewb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  tewb_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .event_time_in  (event_time_in),
    .message_in     (message_in),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .status         (status),
    .event_time_out (event_time_out),
    .message_out    (message_out)
  );

endmodule
